// ===== sv/bgf_pkg.sv =====
`default_nettype none
package bgf_pkg;

  localparam int MV_W   = 16;
  localparam int PCT_W  = 7;
  localparam int STAT_W = 2;
  localparam int RD_W   = 12;
  localparam int SCALE_W = 20;

  localparam logic [1:0] REG_SCALE    = 2'd0;
  localparam logic [1:0] REG_FULL     = 2'd1;
  localparam logic [1:0] REG_CRITICAL = 2'd2;
  localparam logic [1:0] REG_LOW      = 2'd3;

  localparam logic [MV_W-1:0] MV_EMPTY   = 16'd3000;
  localparam logic [MV_W-1:0] MV_KNEE    = 16'd3700;
  localparam logic [MV_W-1:0] MV_UNKNOWN = 16'd500;
  localparam logic [MV_W-1:0] UPPER_SPAN = 16'd500;

  // reciprocals for divide by 14 (10-bit value) and by 10 (9-bit value)
  localparam logic [10:0] RECIP_14 = 11'd1171;
  localparam int          SH_14    = 14;
  localparam logic [9:0]  RECIP_10 = 10'd820;
  localparam int          SH_10    = 13;

  localparam logic [PCT_W-1:0] PCT_ZERO = 7'd0;
  localparam logic [PCT_W-1:0] PCT_HALF = 7'd50;
  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  localparam logic [STAT_W-1:0] BAT_UNKNOWN  = 2'd0;
  localparam logic [STAT_W-1:0] BAT_CRITICAL = 2'd1;
  localparam logic [STAT_W-1:0] BAT_LOW      = 2'd2;
  localparam logic [STAT_W-1:0] BAT_NORMAL   = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPD,
    ST_DIV,
    ST_CLASS
  } back_state_t;

  typedef struct packed {
    logic [MV_W-1:0] full_mv;
    logic [MV_W-1:0] critical_mv;
    logic [MV_W-1:0] low_mv;
  } thresholds_t;

endpackage
`default_nettype wire

// ===== sv/bgf_ram.sv =====
`default_nettype none
module bgf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/bgf_queue.sv =====
`default_nettype none
module bgf_queue import bgf_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire logic [MV_W-1:0] din,
  input  wire logic            pop,
  output logic      [MV_W-1:0] dout,
  output logic                 empty,
  output logic                 full
);

  logic [MV_W-1:0] entry [2];
  logic            wptr;
  logic            rptr;
  logic [1:0]      count;

  assign dout  = entry[rptr];
  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= din;
    end
  end

endmodule
`default_nettype wire

// ===== sv/bgf_front.sv =====
`default_nettype none
module bgf_front import bgf_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [SCALE_W-1:0] scale,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [RD_W-1:0]    reading_a,
  input  wire logic [RD_W-1:0]    reading_b,
  input  wire logic [RD_W-1:0]    reading_c,
  input  wire logic [RD_W-1:0]    reading_d,
  input  wire logic               q_full,
  output logic                    q_push,
  output logic      [MV_W-1:0]    q_din
);

  logic            fe_valid;
  logic [MV_W-1:0] fe_mv;
  logic            accept;
  logic [13:0]     sum;
  logic [RD_W-1:0] code;
  logic [31:0]     prod;

  assign in_stall = fe_valid && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = fe_valid && !q_full;
  assign q_din    = fe_mv;

  assign sum  = 14'(reading_a) + 14'(reading_b) + 14'(reading_c) + 14'(reading_d);
  assign code = sum[13:2];
  // 12 x 20 bits never exceeds 32 bits, so mv needs no saturation
  assign prod = 32'(code) * 32'(scale);

  always_ff @(posedge clk) begin
    if (rst) begin
      fe_valid <= 1'b0;
    end else begin
      fe_valid <= accept || (fe_valid && q_full);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fe_mv <= prod[31:16];
    end
  end

endmodule
`default_nettype wire

// ===== sv/bgf_back.sv =====
`default_nettype none
module bgf_back import bgf_pkg::*; #(
  parameter int FILTER_DEPTH = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire thresholds_t       thr,
  input  wire logic              q_empty,
  input  wire logic [MV_W-1:0]   q_dout,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [MV_W-1:0]   avg_mv,
  output logic      [PCT_W-1:0]  percent,
  output logic      [STAT_W-1:0] bat_state
);

  localparam int SW = $clog2(FILTER_DEPTH);
  localparam int TW = MV_W + SW;
  localparam int SH = TW + SW;
  localparam int MW = TW + 1;
  localparam int PW = TW + MW;
  localparam logic [MW-1:0] RECIP = MW'((2 ** SH + FILTER_DEPTH - 1) / FILTER_DEPTH);
  localparam logic [SW-1:0] LAST_SLOT = SW'(FILTER_DEPTH - 1);

  back_state_t     state;
  back_state_t     state_next;
  logic            ram_re;
  logic            do_upd;
  logic            do_div;
  logic            ld_out;

  logic            primed;
  logic            wrapped;
  logic [SW-1:0]   slot;
  logic [TW-1:0]   total;
  logic [MV_W-1:0] prime_mv;
  logic [MV_W-1:0] cur_mv;
  logic [MV_W-1:0] avg;
  logic [MV_W-1:0] ram_q;
  logic [MV_W-1:0] old_mv;
  logic            ram_we;
  logic [PW-1:0]   div_prod;

  logic [9:0]        x1;
  logic [20:0]       p1;
  logic [MV_W-1:0]   x2;
  logic [18:0]       p2;
  logic [PCT_W-1:0]  pct_calc;
  logic [STAT_W-1:0] stat_calc;

  assign ram_we = do_upd && primed;

  bgf_ram #(
    .WIDTH(MV_W),
    .DEPTH(FILTER_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (cur_mv),
    .re    (ram_re),
    .raddr (slot),
    .rdata (ram_q)
  );

  // entries not yet rewritten since priming hold the priming voltage
  assign old_mv   = wrapped ? ram_q : prime_mv;
  assign div_prod = PW'(total) * PW'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    ram_re     = 1'b0;
    do_upd     = 1'b0;
    do_div     = 1'b0;
    ld_out     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          ram_re     = 1'b1;
          state_next = ST_UPD;
        end
      end
      ST_UPD: begin
        do_upd     = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        do_div     = 1'b1;
        state_next = ST_CLASS;
      end
      ST_CLASS: begin
        if (!out_valid || !out_stall) begin
          ld_out     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      primed  <= 1'b0;
      wrapped <= 1'b0;
      slot    <= '0;
      total   <= '0;
    end else if (do_upd) begin
      if (!primed) begin
        primed  <= 1'b1;
        wrapped <= 1'b0;
        slot    <= '0;
        total   <= TW'(cur_mv) * TW'(FILTER_DEPTH);
      end else begin
        total <= total - TW'(old_mv) + TW'(cur_mv);
        if (slot == LAST_SLOT) begin
          slot    <= '0;
          wrapped <= 1'b1;
        end else begin
          slot <= slot + SW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_mv <= q_dout;
    end
    if (do_upd && !primed) begin
      prime_mv <= cur_mv;
    end
    if (do_div) begin
      avg <= div_prod[SH+MV_W-1:SH];
    end
  end

  // lower segment: (avg-3000)/14, upper segment: 50 + (avg-3700)/10
  assign x1 = 10'(avg - MV_EMPTY);
  assign p1 = 21'(x1) * 21'(RECIP_14);
  assign x2 = avg - MV_KNEE;
  assign p2 = 19'(x2[8:0]) * 19'(RECIP_10);

  always_comb begin
    if (avg <= MV_EMPTY) begin
      pct_calc = PCT_ZERO;
    end else if (avg >= thr.full_mv) begin
      pct_calc = PCT_FULL;
    end else if (avg < MV_KNEE) begin
      pct_calc = p1[SH_14+PCT_W-1:SH_14];
    end else if (x2 >= UPPER_SPAN) begin
      pct_calc = PCT_FULL;
    end else begin
      pct_calc = PCT_HALF + PCT_W'(p2[SH_10+5:SH_10]);
    end
  end

  always_comb begin
    if (avg < MV_UNKNOWN) begin
      stat_calc = BAT_UNKNOWN;
    end else if (avg <= thr.critical_mv) begin
      stat_calc = BAT_CRITICAL;
    end else if (avg <= thr.low_mv) begin
      stat_calc = BAT_LOW;
    end else begin
      stat_calc = BAT_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      avg_mv    <= avg;
      percent   <= pct_calc;
      bat_state <= stat_calc;
    end
  end

endmodule
`default_nettype wire

// ===== sv/battery_gauge_filter.sv =====
`default_nettype none
// channel   direction  handshake              payload
// config    in         psel/penable/pwrite    paddr[3:0], pwdata[31:0], prdata[31:0]
// input     in         in_valid / in_stall    reading_a..reading_d, 12 bits each
// result    out        out_valid / out_stall  avg_mv[15:0], percent[6:0], bat_state[1:0]
//
// front takes an item per cycle, unless in_stall holds it, into a scale multiply stage, then a 2-entry queue
// back handles each item in order: store read, total update, reciprocal divide, classify
// the back sequencer takes no new item until the result of the last one is loaded
// the first item after reset primes the average store, no clearing pass is needed
// in_stall rises when the front stage holds an item and the queue is full
// a held result stops the back, the queue then fills and stalls the front
module battery_gauge_filter import bgf_pkg::*; #(
  parameter int FILTER_DEPTH = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [RD_W-1:0]   reading_a,
  input  wire logic [RD_W-1:0]   reading_b,
  input  wire logic [RD_W-1:0]   reading_c,
  input  wire logic [RD_W-1:0]   reading_d,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [MV_W-1:0]   avg_mv,
  output logic      [PCT_W-1:0]  percent,
  output logic      [STAT_W-1:0] bat_state
);

  logic [SCALE_W-1:0] scale;
  thresholds_t        thr;
  logic [1:0]         reg_idx;
  logic               cfg_we;
  logic               q_push;
  logic               q_pop;
  logic [MV_W-1:0]    q_din;
  logic [MV_W-1:0]    q_dout;
  logic               q_empty;
  logic               q_full;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale           <= 20'd80018;
      thr.full_mv     <= 16'd4200;
      thr.critical_mv <= 16'd3300;
      thr.low_mv      <= 16'd3500;
    end else if (cfg_we) begin
      case (reg_idx)
        REG_SCALE:    scale           <= pwdata[SCALE_W-1:0];
        REG_FULL:     thr.full_mv     <= pwdata[MV_W-1:0];
        REG_CRITICAL: thr.critical_mv <= pwdata[MV_W-1:0];
        REG_LOW:      thr.low_mv      <= pwdata[MV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SCALE:    prdata = 32'(scale);
      REG_FULL:     prdata = 32'(thr.full_mv);
      REG_CRITICAL: prdata = 32'(thr.critical_mv);
      REG_LOW:      prdata = 32'(thr.low_mv);
      default:      prdata = '0;
    endcase
  end

  bgf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .scale     (scale),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .reading_a (reading_a),
    .reading_b (reading_b),
    .reading_c (reading_c),
    .reading_d (reading_d),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_din     (q_din)
  );

  bgf_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty),
    .full  (q_full)
  );

  bgf_back #(
    .FILTER_DEPTH(FILTER_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .thr       (thr),
    .q_empty   (q_empty),
    .q_dout    (q_dout),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .avg_mv    (avg_mv),
    .percent   (percent),
    .bat_state (bat_state)
  );

endmodule
`default_nettype wire
